// File: rtl/iirl_pkg.sv
package iirl_pkg;

    localparam int CAPACITY  = 16;
    localparam int POS_W     = 5;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 5;
    localparam int CMD_W     = 2;
    localparam int STS_W     = 2;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// File: rtl/iirl_req_if.sv
interface iirl_req_if;
    import iirl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// File: rtl/iirl_rsp_if.sv
interface iirl_rsp_if;
    import iirl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STS_W-1:0]         status;
    logic signed [VAL_W-1:0]  read_value;
    logic [CNT_OUT_W-1:0]     entry_count;

    modport source (output valid, output status, output read_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_count,
                    output ready);
endinterface

// File: rtl/indexed_insert_remove_list.sv
// Bounded ordered list of up to 16 signed 32-bit entries. Each request item carries a command
// (insert, remove or read), a position and a value; each gives exactly one response item with
// a status (done, position out of range, list full), the read value and the entry count after
// the operation. An item's request is registered in the idle state; then, in the execute
// state, once the response register is free or being emptied, the cells shift (for an insert
// or remove) and the response register is loaded. The response register lets the next item
// enter while a response waits. Reset empties the list at once.
module indexed_insert_remove_list (
    input  logic  i_clk,
    input  logic  i_rst_n,
    iirl_req_if.sink   i_req,
    iirl_rsp_if.source o_rsp
);
    import iirl_pkg::*;

    t_dp_cmd dp_cmd;

    iirl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_dp        (dp_cmd)
    );

    iirl_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp          (dp_cmd),
        .i_cmd         (i_req.cmd),
        .i_position    (i_req.position),
        .i_value       (i_req.value),
        .o_status      (o_rsp.status),
        .o_read_value  (o_rsp.read_value),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

// File: rtl/iirl_ctrl.sv
module iirl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output iirl_pkg::t_dp_cmd o_dp
);
    import iirl_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_take;
    logic   exec_ok;

    assign out_take = r_out_valid && i_out_ready;
    // the output register must be free, or emptied this cycle, before an item executes
    assign exec_ok  = (r_state == S_EXEC) && (!r_out_valid || out_take);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_dp.load    = (r_state == S_IDLE) && i_in_valid;
        o_dp.exec    = exec_ok;
        o_out_valid  = r_out_valid;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (exec_ok) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_exec_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp.exec |=> r_out_valid)
        else $error("result not presented after execute");

    a_no_load_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !o_dp.load)
        else $error("item loaded while another is pending");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result dropped without being taken");

endmodule

// File: rtl/iirl_datapath.sv
module iirl_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iirl_pkg::t_dp_cmd                 i_dp,
    input  logic [iirl_pkg::CMD_W-1:0]        i_cmd,
    input  logic [iirl_pkg::POS_W-1:0]        i_position,
    input  logic signed [iirl_pkg::VAL_W-1:0] i_value,
    output logic [iirl_pkg::STS_W-1:0]        o_status,
    output logic signed [iirl_pkg::VAL_W-1:0] o_read_value,
    output logic [iirl_pkg::CNT_OUT_W-1:0]    o_entry_count
);
    import iirl_pkg::*;

    logic [CMD_W-1:0]         r_cmd;
    logic [POS_W-1:0]         r_pos;
    logic signed [VAL_W-1:0]  r_val;
    logic [VAL_W-1:0]         r_entries [CAPACITY];
    logic [VAL_W-1:0]         n_entries [CAPACITY];
    logic [CNT_W-1:0]         r_count, n_count;
    logic [STS_W-1:0]         r_status, n_status;
    logic signed [VAL_W-1:0]  r_rd, n_rd;
    logic [CNT_OUT_W-1:0]     r_cnt_out;
    logic [CMP_W-1:0]         pos_c, cnt_c;
    logic                     full;

    assign pos_c = CMP_W'(r_pos);
    assign cnt_c = CMP_W'(r_count);
    assign full  = (r_count == CNT_W'(CAPACITY));

    always_ff @(posedge i_clk) begin
        if (i_dp.load) begin
            r_cmd <= i_cmd;
            r_pos <= i_position;
            r_val <= i_value;
        end
    end

    // slots at and above the count always hold zero, so cells shift without regard to the count
    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_status  = STS_RANGE;
        n_rd      = '0;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (pos_c > cnt_c) begin
                    n_status = STS_RANGE;
                end else if (full) begin
                    n_status = STS_FULL;
                end else begin
                    if (pos_c == '0) begin
                        n_entries[0] = r_val;
                    end
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (CMP_W'(i) > pos_c) begin
                            n_entries[i] = r_entries[i-1];
                        end else if (CMP_W'(i) == pos_c) begin
                            n_entries[i] = r_val;
                        end
                    end
                    n_count  = r_count + CNT_W'(1);
                    n_status = STS_DONE;
                end
            end
            CMD_REMOVE: begin
                if (pos_c < cnt_c) begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (CMP_W'(i) >= pos_c) begin
                            n_entries[i] = r_entries[i+1];
                        end
                    end
                    n_entries[CAPACITY-1] = '0;
                    n_count  = r_count - CNT_W'(1);
                    n_status = STS_DONE;
                end
            end
            CMD_READ: begin
                if (pos_c <= cnt_c) begin
                    if (pos_c < cnt_c) begin
                        n_rd = r_entries[IDX_W'(r_pos)];
                    end
                    n_status = STS_DONE;
                end
            end
            default: n_status = STS_RANGE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_entries[i] <= '0;
            end
        end else if (i_dp.exec) begin
            r_count   <= n_count;
            r_entries <= n_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp.exec) begin
            r_status  <= n_status;
            r_rd      <= n_rd;
            r_cnt_out <= CNT_OUT_W'(n_count);
        end
    end

    assign o_status      = r_status;
    assign o_read_value  = r_rd;
    assign o_entry_count = r_cnt_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_dp.exec |=> $stable(r_count))
        else $error("count changed without an execute");

    a_free_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < CNT_W'(CAPACITY)) |-> (r_entries[IDX_W'(r_count)] == '0))
        else $error("slot at the count is not clear");

endmodule
